// ===== rtl/core/hra_pkg.sv =====
// Shared types and constants for the hardcopy request arbiter.
// No dependencies; imported by hardcopy_request_arbiter.
package hra_pkg;

	// Fixed field widths of the stream words
	localparam int STATION_W = 5;
	localparam int JOB_W     = 4;
	localparam int ACTION_W  = 2;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	// Default sizing of the reservation matrix
	localparam int DEF_NUM_STATIONS     = 16;
	localparam int DEF_JOBS_PER_STATION = 8;

	// Request kinds carried on the input tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_NEW     = 2'd0,
		ACT_CONT    = 2'd1,
		ACT_OFFLINE = 2'd2,
		ACT_END     = 2'd3
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEW_WR,
		ST_REL_WR,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/hardcopy_request_arbiter.sv =====
// Hardcopy request arbiter: one grant at a time, reservations kept in a row memory.
// Depends on hra_pkg (widths, request kinds, sequencer states).
//
// Channel   Dir  Handshake                     Word
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: station, job_number
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: first_message; tdata: job, station
//
// One request is taken at a time. A continue or an immediate grant passes through the
// emit state, a reservation through the write state, a release through the write and scan
// states: the scan reads one station row per cycle through the memory's registered read port.
// arst_n clears the grant and every row valid bit, so the matrix reads as empty.
// The result register holds a word until taken; a new request is still accepted,
// and only a second result waits in the emit state.
module hardcopy_request_arbiter
	import hra_pkg::*;
#(
	parameter int NUM_STATIONS     = DEF_NUM_STATIONS,
	parameter int JOBS_PER_STATION = DEF_JOBS_PER_STATION
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [4:0] station, [8:5] job_number
	input  logic [ACTION_W-1:0]  s_axis_tuser,   // [1:0] action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // [3:0] granted_job, [8:4] granted_station
	output logic                 m_axis_tuser    // [0] first_message
);

	localparam int ROW_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int COL_W = (JOBS_PER_STATION > 1) ? $clog2(JOBS_PER_STATION) : 1;
	localparam int CNT_W = $clog2(NUM_STATIONS + 1);
	localparam int J     = JOBS_PER_STATION;

	// Reservation memory and per-row valid bits
	logic [J-1:0]            mem_q [NUM_STATIONS];
	logic [NUM_STATIONS-1:0] row_vld_q;
	logic [J-1:0]            rd_data_q;
	logic                    rd_vld_q;

	state_t                  state_q, state_d;
	logic [STATION_W-1:0]    active_station_q;
	logic [JOB_W-1:0]        active_job_q;
	logic                    first_q;
	logic [ROW_W-1:0]        req_row_q;
	logic [J-1:0]            req_mask_q;
	logic [CNT_W-1:0]        scan_cnt_q;
	logic                    scan_pend_s1;
	logic [ROW_W-1:0]        scan_row_s1;
	logic                    out_valid_q;
	logic                    out_first_q;
	logic [JOB_W-1:0]        out_job_q;
	logic [STATION_W-1:0]    out_station_q;

	logic                    s_accept;
	action_t                 in_action;
	logic [STATION_W-1:0]    in_station;
	logic [JOB_W-1:0]        in_job;
	logic                    st_ok, job_ok, active_idle, out_free;
	logic [ROW_W-1:0]        in_row, act_row, rd_addr, mem_waddr;
	logic [J-1:0]            in_mask, act_mask, row_data, mem_wdata;
	logic                    mem_we, vld_clr;
	logic                    row_hit;
	logic [COL_W-1:0]        hit_col;

	// Input word decode
	assign in_action   = action_t'(s_axis_tuser);
	assign in_station  = s_axis_tdata[STATION_W-1:0];
	assign in_job      = s_axis_tdata[STATION_W+JOB_W-1:STATION_W];
	assign st_ok       = (in_station != '0) && (in_station <= STATION_W'(NUM_STATIONS));
	assign job_ok      = (in_job != '0) && (in_job <= JOB_W'(JOBS_PER_STATION));
	assign in_row      = ROW_W'(in_station - STATION_W'(1));
	assign in_mask     = J'(1) << COL_W'(in_job - JOB_W'(1));
	assign active_idle = (active_station_q == '0);
	assign act_row     = ROW_W'(active_station_q - STATION_W'(1));
	assign act_mask    = J'(1) << COL_W'(active_job_q - JOB_W'(1));
	assign out_free    = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Row read back, an invalid row reads as empty
	assign row_data = rd_vld_q ? rd_data_q : '0;

	// Lowest set job in the row just read
	always_comb begin
		row_hit = |row_data;
		hit_col = '0;
		for (int i = J - 1; i >= 0; i--) begin
			if (row_data[i]) begin
				hit_col = COL_W'(i);
			end
		end
	end

	// Next state and memory control
	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		vld_clr   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					unique case (in_action)
						ACT_NEW: begin
							rd_addr = in_row;
							if (st_ok && job_ok) begin
								state_d = active_idle ? ST_EMIT : ST_NEW_WR;
							end
						end
						ACT_CONT: begin
							state_d = ST_EMIT;
						end
						ACT_OFFLINE: begin
							if (st_ok) begin
								vld_clr = 1'b1;
								// row already empty, go straight to the scan
								if (in_station == active_station_q) begin
									state_d = ST_SCAN;
								end
							end
						end
						ACT_END: begin
							rd_addr = act_row;
							state_d = active_idle ? ST_SCAN : ST_REL_WR;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_NEW_WR: begin
				mem_we    = 1'b1;
				mem_waddr = req_row_q;
				mem_wdata = row_data | req_mask_q;
				state_d   = ST_IDLE;
			end
			ST_REL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = act_row;
				mem_wdata = row_data & ~act_mask;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_cnt_q < CNT_W'(NUM_STATIONS)) begin
					rd_addr = scan_cnt_q[ROW_W-1:0];
				end
				if (scan_pend_s1 && row_hit) begin
					state_d = ST_EMIT;
				end else if (scan_pend_s1 && (scan_row_s1 == ROW_W'(NUM_STATIONS - 1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= row_vld_q[rd_addr];
	end

	// Row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else begin
			if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end
			if (vld_clr) begin
				row_vld_q[in_row] <= 1'b0;
			end
		end
	end

	// Sequencer, grant and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			active_station_q <= '0;
			active_job_q     <= '0;
			scan_cnt_q       <= '0;
			scan_pend_s1     <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			// grant register
			if (state_q == ST_IDLE && s_accept) begin
				if (in_action == ACT_NEW && st_ok && job_ok && active_idle) begin
					active_station_q <= in_station;
					active_job_q     <= in_job;
				end else if (in_action == ACT_OFFLINE && st_ok &&
				             in_station == active_station_q) begin
					active_station_q <= '0;
					active_job_q     <= '0;
				end
			end else if (state_q == ST_REL_WR) begin
				active_station_q <= '0;
				active_job_q     <= '0;
			end else if (state_q == ST_SCAN && scan_pend_s1 && row_hit) begin
				active_station_q <= STATION_W'(scan_row_s1) + STATION_W'(1);
				active_job_q     <= JOB_W'(hit_col) + JOB_W'(1);
			end

			// scan counter and read-pending flag
			if (state_q != ST_SCAN) begin
				scan_cnt_q   <= '0;
				scan_pend_s1 <= 1'b0;
			end else if (scan_cnt_q < CNT_W'(NUM_STATIONS)) begin
				scan_cnt_q   <= scan_cnt_q + CNT_W'(1);
				scan_pend_s1 <= 1'b1;
			end else begin
				scan_pend_s1 <= 1'b0;
			end

			// result word valid
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_accept) begin
			req_row_q  <= in_row;
			req_mask_q <= in_mask;
			first_q    <= (in_action == ACT_NEW);
		end else if (state_q == ST_SCAN && scan_pend_s1 && row_hit) begin
			first_q <= 1'b1;
		end
		scan_row_s1 <= scan_cnt_q[ROW_W-1:0];
		if (state_q == ST_EMIT && out_free) begin
			out_first_q   <= first_q;
			out_job_q     <= active_job_q;
			out_station_q <= active_station_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_first_q;
	assign m_axis_tdata  = M_TDATA_W'({out_station_q, out_job_q});

endmodule
